// ===== rtl/med_pkg.sv =====
// Shared constants, types and register codes for the 3x3 erode/dilate filter.
// No dependencies; imported by every module of the block.
package med_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic           mode;
        logic [COL_W:0] width;
        logic [ROW_W:0] height;
    } t_cfg;

    typedef struct packed {
        logic             has_int;
        logic             has_bord;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last;
    } t_result;

endpackage

// ===== rtl/med_front.sv =====
// Front end: raster position tracking, two line stores, 3x3 window and result classification.
// Depends on med_pkg. Feeds classified pixel entries into med_fifo.
module med_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  med_pkg::t_cfg                    i_cfg,
    input  logic                             i_accept,
    input  logic [med_pkg::PIX_W-1:0]        i_pixel,
    input  logic                             i_frame_start,
    output logic                             o_busy,
    output logic                             o_push,
    output med_pkg::t_entry                  o_entry
);
    import med_pkg::*;

    logic [PIX_W-1:0] r_prev_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] r_older_mem [MAX_WIDTH];

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;

    logic             r_b_valid;
    logic             r_b_hit;
    logic             r_b_int;
    logic             r_b_bord;
    logic [ROW_W-1:0] r_b_row;
    logic [COL_W-1:0] r_b_col;
    logic [PIX_W-1:0] r_b_px;
    logic [PIX_W-1:0] r_mem_prev;
    logic [PIX_W-1:0] r_mem_older;
    logic [PIX_W-1:0] r_fwd_prev;
    logic [PIX_W-1:0] r_fwd_older;
    logic [PIX_W-1:0] r_win [6];

    logic [ROW_W:0]   s_row;
    logic [COL_W-1:0] s_col;
    logic [ROW_W-1:0] a_row;
    logic [COL_W-1:0] a_col;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             a_int;
    logic             a_bord;

    logic [PIX_W-1:0] b_prev;
    logic [PIX_W-1:0] b_older;
    logic [PIX_W-1:0] win [9];
    logic [PIX_W-1:0] target;
    logic             any_hit;

    // position of the arriving pixel and of the one after it
    always_comb begin
        s_row = i_frame_start ? '0 : {1'b0, r_row};
        s_col = i_frame_start ? '0 : r_col;
        if ({1'b0, s_col} >= i_cfg.width) begin
            s_col = '0;
            s_row = s_row + 1'b1;
        end
        if (s_row >= i_cfg.height) begin
            s_row = '0;
        end
        a_row   = s_row[ROW_W-1:0];
        a_col   = s_col;
        col_inc = {1'b0, a_col} + 1'b1;
        row_inc = {1'b0, a_row} + 1'b1;
        if (col_inc >= i_cfg.width) begin
            n_col = '0;
            n_row = (row_inc >= i_cfg.height) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = a_row;
        end
        a_int  = (a_row >= ROW_W'(2)) && (a_col >= COL_W'(2));
        a_bord = (a_row == '0) || ({1'b0, a_row} == i_cfg.height - 1'b1)
              || (a_col == '0) || ({1'b0, a_col} == i_cfg.width - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_accept;
            if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_hit  <= r_b_valid && (r_b_col == a_col);
            r_b_int  <= a_int;
            r_b_bord <= a_bord;
            r_b_row  <= a_row;
            r_b_col  <= a_col;
            r_b_px   <= i_pixel;
        end
    end

    // line stores: read at accept, written in the cycle after
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mem_prev <= r_prev_mem[a_col];
        end
        if (r_b_valid) begin
            r_prev_mem[r_b_col] <= r_b_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mem_older <= r_older_mem[a_col];
        end
        if (r_b_valid) begin
            r_older_mem[r_b_col] <= b_prev;
        end
    end

    // bypass when the previous pixel wrote the same column in the read cycle
    assign b_prev  = r_b_hit ? r_fwd_prev  : r_mem_prev;
    assign b_older = r_b_hit ? r_fwd_older : r_mem_older;

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_fwd_prev  <= r_b_px;
            r_fwd_older <= b_prev;
            r_win[0]    <= r_win[3];
            r_win[1]    <= r_win[4];
            r_win[2]    <= r_win[5];
            r_win[3]    <= b_older;
            r_win[4]    <= b_prev;
            r_win[5]    <= r_b_px;
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            win[i] = r_win[i];
        end
        win[6] = b_older;
        win[7] = b_prev;
        win[8] = r_b_px;
        target  = (i_cfg.mode == MODE_DILATE) ? PIX_MAX : PIX_MIN;
        any_hit = 1'b0;
        for (int i = 0; i < 9; i++) begin
            any_hit = any_hit | (win[i] == target);
        end
    end

    assign o_busy           = r_b_valid;
    assign o_push           = r_b_valid && (r_b_int || r_b_bord);
    assign o_entry.has_int  = r_b_int;
    assign o_entry.has_bord = r_b_bord;
    assign o_entry.row      = r_b_row;
    assign o_entry.col      = r_b_col;
    assign o_entry.pixel    = r_b_px;
    assign o_entry.value    = any_hit ? target : win[4];

endmodule

// ===== rtl/med_fifo.sv =====
// Short entry queue between the front end and the result serializer.
// Depends on med_pkg for depth and entry type.
module med_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  med_pkg::t_entry             i_entry,
    input  logic                        i_pop,
    output med_pkg::t_entry             o_entry,
    output logic                        o_empty,
    output logic [med_pkg::Q_CNT_W-1:0] o_count
);
    import med_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != Q_CNT_W'(Q_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

endmodule

// ===== rtl/med_back.sv =====
// Back end: splits each queue entry into one or two results and holds them in an output register.
// Depends on med_pkg. Drains med_fifo.
module med_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  med_pkg::t_entry             i_entry,
    input  logic                        i_q_empty,
    output logic                        o_deq,
    input  logic                        i_pop,
    output logic                        o_empty,
    output med_pkg::t_result            o_result
);
    import med_pkg::*;

    logic    r_out_valid;
    logic    r_half;
    t_result r_out;
    t_result n_out;
    logic    n_half;
    logic    load;

    assign load = !r_out_valid || i_pop;

    always_comb begin
        n_half = r_half;
        o_deq  = 1'b0;
        if (!r_half && i_entry.has_int) begin
            n_out.row   = i_entry.row - 1'b1;
            n_out.col   = i_entry.col - 1'b1;
            n_out.value = i_entry.value;
            n_out.last  = !i_entry.has_bord;
            if (i_entry.has_bord) begin
                n_half = 1'b1;
            end else begin
                o_deq = 1'b1;
            end
        end else begin
            n_out.row   = i_entry.row;
            n_out.col   = i_entry.col;
            n_out.value = i_entry.pixel;
            n_out.last  = 1'b1;
            n_half      = 1'b0;
            o_deq       = 1'b1;
        end
        if (!load || i_q_empty) begin
            o_deq  = 1'b0;
            n_half = r_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            r_half <= n_half;
            if (load) begin
                r_out_valid <= !i_q_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            r_out <= n_out;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    a_half_keeps_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> !i_q_empty)
        else $error("split entry left the queue early");

    a_half_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_out_valid && !r_out.last))
        else $error("first half of a split entry marked last");

endmodule

// ===== rtl/morph_erode_dilate_3x3.sv =====
// Top level of the 3x3 erode/dilate filter: configuration registers and block wiring.
// Depends on med_pkg, med_front, med_fifo and med_back.
//
// Pixels enter in raster order at up to one per clock; full rises only when the
// entry queue count plus the entry in flight in the front end reaches four.
// Each pixel yields zero, one or two results (delayed interior result first,
// then the border pass-through), delivered at one result per clock from the
// output register while pop is high; a run of two-result pixels fills the queue.
// Results pass the front-end register, entry queue and output register. Line stores
// are 1024 x 8 single-write memories; configuration (mode, width clamped to 3..1024,
// height clamped to 3..4096) must be written only while idle; the block does not enforce it.
module morph_erode_dilate_3x3 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [12:0]                 i_cfg_data,
    input  logic [med_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_frame_start,
    input  logic                        push,
    output logic                        full,
    output logic [med_pkg::ROW_W-1:0]   o_out_row,
    output logic [med_pkg::COL_W-1:0]   o_out_col,
    output logic [med_pkg::PIX_W-1:0]   o_out_value,
    output logic                        o_last,
    output logic                        empty,
    input  logic                        pop
);
    import med_pkg::*;

    logic           r_mode;
    logic [COL_W:0] r_width;
    logic [ROW_W:0] r_height;
    t_cfg           cfg;

    logic               accept;
    logic               front_busy;
    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic [Q_CNT_W-1:0] q_count;
    logic [Q_CNT_W:0]   q_used;
    t_entry             q_in;
    t_entry             q_out;
    t_result            result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ERODE;
            r_width  <= (COL_W+1)'(MAX_WIDTH);
            r_height <= (ROW_W+1)'(1024);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= i_cfg_data[COL_W:0];
                CFG_HEIGHT: r_height <= i_cfg_data[ROW_W:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.mode = r_mode;
        if (r_width < (COL_W+1)'(3)) begin
            cfg.width = (COL_W+1)'(3);
        end else if (r_width > (COL_W+1)'(MAX_WIDTH)) begin
            cfg.width = (COL_W+1)'(MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        if (r_height < (ROW_W+1)'(3)) begin
            cfg.height = (ROW_W+1)'(3);
        end else if (r_height > (ROW_W+1)'(MAX_HEIGHT)) begin
            cfg.height = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            cfg.height = r_height;
        end
    end

    assign q_used = {1'b0, q_count} + (Q_CNT_W+1)'(front_busy);
    assign full   = (q_used >= (Q_CNT_W+1)'(Q_DEPTH));
    assign accept = push && !full;

    med_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (accept),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_busy        (front_busy),
        .o_push        (q_push),
        .o_entry       (q_in)
    );

    med_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    med_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (q_out),
        .i_q_empty (q_empty),
        .o_deq     (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_out_row   = result.row;
    assign o_out_col   = result.col;
    assign o_out_value = result.value;
    assign o_last      = result.last;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for morph_erode_dilate_3x3: directed frames, size and
// clamp sweeps, back-pressure and random frames checked against a local predictor.
// Depends on med_pkg and the morph_erode_dilate_3x3 RTL.
module testbench;
    import med_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 60;
    localparam int MAX_REPORTS   = 40;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_kind;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = CFG_MODE;
    logic [12:0]       i_cfg_data = '0;
    logic [PIX_W-1:0]  i_pixel = '0;
    logic              i_frame_start = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [ROW_W-1:0]  o_out_row;
    logic [COL_W-1:0]  o_out_col;
    logic [PIX_W-1:0]  o_out_value;
    logic              o_last;
    logic              empty;
    logic              pop = 1'b0;

    morph_erode_dilate_3x3 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pixel      (i_pixel),
        .i_frame_start(i_frame_start),
        .push         (push),
        .full         (full),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_last       (o_last),
        .empty        (empty),
        .pop          (pop)
    );

    // filter state mirror
    logic             flt_mode = MODE_ERODE;
    logic [10:0]      flt_width = 11'd1024;
    logic [12:0]      flt_height = 13'd1024;
    logic [PIX_W-1:0] prev_row [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] older_row [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] win_cols [0:5];
    int unsigned      row_pos = 0;
    int unsigned      col_pos = 0;

    t_result          due_results [$];
    t_result          want;

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int fail_count = 0;
    int report_count = 0;
    int pixel_count = 0;
    int result_count = 0;
    int cfg_count = 0;
    int full_cycles = 0;

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            prev_row[i] = '0;
            older_row[i] = '0;
        end
        for (int i = 0; i < 6; i++) win_cols[i] = '0;
    end

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL morph_erode_dilate_3x3");
        $finish;
    end

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 2) return PIX_MIN;
        if (pick < 4) return PIX_MAX;
        if (pick == 4) return $urandom_range(1) ? 8'd1 : 8'd254;
        return PIX_W'($urandom_range(255));
    endfunction

    task automatic run_window_filter(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned w, h, r, c;
        logic [PIX_W-1:0] win [0:8];
        logic [PIX_W-1:0] target, v;
        bit has_int, has_bord;
        t_result int_res, bord_res;
        w = clamp_range(flt_width, 3, MAX_WIDTH);
        h = clamp_range(flt_height, 3, MAX_HEIGHT);
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        for (int i = 0; i < 6; i++) win[i] = win_cols[i];
        win[6] = older_row[c];
        win[7] = prev_row[c];
        win[8] = pix;

        has_int = (r >= 2) && (c >= 2);
        has_bord = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
        target = (flt_mode == MODE_DILATE) ? PIX_MAX : PIX_MIN;
        v = win[4];
        for (int i = 0; i < 9; i++) if (win[i] == target) v = target;
        int_res.row = ROW_W'(r - 1);
        int_res.col = COL_W'(c - 1);
        int_res.value = v;
        int_res.last = !has_bord;
        bord_res.row = ROW_W'(r);
        bord_res.col = COL_W'(c);
        bord_res.value = pix;
        bord_res.last = 1'b1;
        if (has_int) due_results.push_back(int_res);
        if (has_bord) due_results.push_back(bord_res);

        for (int i = 0; i < 3; i++) win_cols[i] = win_cols[i + 3];
        win_cols[3] = win[6];
        win_cols[4] = win[7];
        win_cols[5] = win[8];
        older_row[c] = win[7];
        prev_row[c] = pix;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // input and config transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                pixel_count++;
                run_window_filter(i_pixel, i_frame_start);
            end
            if (push && full) full_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_count++;
                case (i_cfg_index)
                    CFG_MODE:   flt_mode = i_cfg_data[0];
                    CFG_WIDTH:  flt_width = i_cfg_data[10:0];
                    CFG_HEIGHT: flt_height = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    task automatic report_mismatch(input string field, input int exp_v, input int got_v);
        fail_count++;
        if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
        end
    endtask

    // result transactions
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            result_count++;
            if (due_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result row %0d col %0d value %0d last %0b",
                         $time, o_out_row, o_out_col, o_out_value, o_last);
            end else begin
                want = due_results.pop_front();
                if (o_out_row !== want.row) report_mismatch("row", want.row, o_out_row);
                if (o_out_col !== want.col) report_mismatch("col", want.col, o_out_col);
                if (o_out_value !== want.value)
                    report_mismatch("value", want.value, o_out_value);
                if (o_last !== want.last) report_mismatch("last", want.last, o_last);
            end
        end
    end

    // receiver: random stalls plus long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_idling(input t_idle_kind kind);
        case (kind)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 57; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 57; end
            default:       begin gap_pct = 17; stall_pct = 17; end
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        while ($urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (full);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic mode, input logic [12:0] w_data,
                             input logic [12:0] h_data, input bit poke_unused);
        wait_idle();
        write_reg(CFG_MODE, {12'($urandom_range(4095)), mode});
        write_reg(CFG_WIDTH, w_data);
        write_reg(CFG_HEIGHT, h_data);
        if (poke_unused) write_reg(CFG_UNUSED, 13'($urandom_range(8191)));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input int unsigned count, input logic first_fs);
        for (int unsigned k = 0; k < count; k++) send_pixel(rand_pixel(), first_fs && k == 0);
    endtask

    task automatic test_erode_directed();
        logic [PIX_W-1:0] img [0:15] = '{8'd10, 8'd20, 8'd30, 8'd40,
                                         8'd50, 8'd60, 8'd70, 8'd80,
                                         8'd90, 8'd255, 8'd110, 8'd120,
                                         8'd130, 8'd140, 8'd150, 8'd0};
        set_idling(IDLE_NONE);
        configure(MODE_ERODE, 13'd4, 13'd4, 1'b0);
        for (int k = 0; k < 16; k++) send_pixel(img[k], k == 0);
    endtask

    task automatic test_dilate_directed();
        logic [PIX_W-1:0] img [0:8] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd200,
                                        8'd6, 8'd7, 8'd128, 8'd255};
        configure(MODE_DILATE, 13'd3, 13'd3, 1'b0);
        for (int k = 0; k < 9; k++) send_pixel(img[k], k == 0);
    endtask

    task automatic test_size_clamp_low();
        set_idling(IDLE_BOTH);
        configure(MODE_DILATE, 13'd2, 13'd0, 1'b1);
        send_frame(9, 1'b1);
        send_frame(9, 1'b0);
        configure(MODE_ERODE, 13'd1, 13'd2, 1'b0);
        send_frame(18, 1'b1);
    endtask

    task automatic test_size_clamp_high();
        set_idling(IDLE_RECEIVER);
        configure(MODE_ERODE, 13'h1FFF, 13'h1FFF, 1'b0);
        send_frame(MAX_WIDTH + 4, 1'b1);
        configure(MODE_DILATE, 13'd1025, 13'd4097, 1'b0);
        send_frame(8, 1'b1);
    endtask

    task automatic test_shrink_mid_frame();
        set_idling(IDLE_SENDER);
        configure(MODE_ERODE, 13'd8, 13'd6, 1'b0);
        send_frame(29, 1'b1);
        configure(MODE_DILATE, 13'd4, 13'd4, 1'b0);
        send_frame(20, 1'b0);
        configure(MODE_DILATE, 13'd4, 13'd3, 1'b0);
        send_frame(14, 1'b0);
    endtask

    task automatic test_backpressure();
        set_idling(IDLE_NONE);
        configure(MODE_DILATE, 13'd6, 13'd5, 1'b0);
        hold_request = 300;
        send_frame(90, 1'b1);
    endtask

    task automatic test_random_frames();
        int unsigned sent, w, h, frames, phase;
        logic fs;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            set_idling(t_idle_kind'(phase % 4));
            w = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(3, 10);
            h = $urandom_range(3, 8);
            configure(1'($urandom_range(1)), 13'(w), 13'(h), 1'b0);
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++) begin
                for (int unsigned k = 0; k < w * h; k++) begin
                    if (k == 0) fs = (f == 0) || ($urandom_range(7) != 0);
                    else fs = ($urandom_range(199) == 0);
                    send_pixel(rand_pixel(), fs);
                    sent++;
                end
            end
            phase++;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_erode_directed();
        test_dilate_directed();
        test_size_clamp_low();
        test_shrink_mid_frame();
        test_backpressure();
        test_size_clamp_high();
        test_random_frames();
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered erode and dilate over %0d pixels, %0d results, %0d register writes,",
                 pixel_count, result_count, cfg_count);
        $display("clamped and shrunk frame sizes, and %0d cycles of input back-pressure.",
                 full_cycles);
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("PASS morph_erode_dilate_3x3");
        end else begin
            $display("FAIL morph_erode_dilate_3x3");
        end
        $finish;
    end
endmodule
